// ----- rtl/hte_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types, constants and helpers of the html text extractor.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int TagDepth   = 9;
    localparam int EntDepth   = 6;
    localparam int OutMax     = 16;
    localparam int QueueDepth = 4;
    localparam int OutDepth   = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       is_end;
        logic       from_last;
    } t_token;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_result;

    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChSpace = 8'h20;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z") begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/hte_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hte_queue
// Short request queue between the tag front and the text back.
// ----------------------------------------------------------------------------
module hte_queue #(
    parameter int DEPTH = hte_pkg::QueueDepth
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  hte_pkg::t_token      i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output hte_pkg::t_token      o_data,
    output logic                 o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hte_pkg::t_token r_mem [DEPTH];
    logic [PW-1:0]   r_head, r_tail;
    logic [CW-1:0]   r_count;
    logic            wr, rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_tail <= (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (rd) begin
                r_head <= (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            r_count <= r_count + CW'(wr) - CW'(rd);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hte_tag_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hte_tag_front
// Tag lookahead window: strips tags, script and style, marks line breaks.
// ----------------------------------------------------------------------------
module hte_tag_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_full,
    output logic             o_tok_push,
    output hte_pkg::t_token  o_tok,
    input  wire logic        i_tok_full
);
    localparam int TD = hte_pkg::TagDepth;

    logic [7:0] r_win [TD];
    logic [3:0] r_fill, n_fill;
    logic [3:0] r_skip, n_skip;
    logic       r_in_tag, n_in_tag;
    logic       r_script_on, n_script_on;
    logic       r_style_on, n_style_on;
    logic       r_draining, n_draining;

    logic [7:0] x  [TD];
    logic [7:0] lx [TD];
    logic [3:0] f;
    logic       acc, do_front, end_push, closed;
    logic       m_sopen, m_sclose, m_stopen, m_stclose, m_nl;

    assign o_full   = r_draining || i_tok_full;
    assign acc      = i_push && !o_full;
    assign do_front = (acc && r_fill == 4'(TD - 1))
                   || (r_draining && r_fill != '0 && !i_tok_full);
    assign end_push = r_draining && r_fill == '0 && !i_tok_full;
    assign f        = r_draining ? r_fill : 4'(TD);

    always_comb begin
        for (int k = 0; k < TD; k++) begin
            x[k]  = (k == TD - 1 && !r_draining) ? i_in_byte : r_win[k];
            lx[k] = hte_pkg::to_lower(x[k]);
        end
    end

    assign m_sopen  = f >= 4'd7 && lx[1] == "s" && lx[2] == "c" && lx[3] == "r"
                   && lx[4] == "i" && lx[5] == "p" && lx[6] == "t";
    assign m_sclose = f >= 4'd9 && lx[1] == "/" && lx[2] == "s" && lx[3] == "c"
                   && lx[4] == "r" && lx[5] == "i" && lx[6] == "p" && lx[7] == "t"
                   && lx[8] == ">";
    assign m_stopen = f >= 4'd6 && lx[1] == "s" && lx[2] == "t" && lx[3] == "y"
                   && lx[4] == "l" && lx[5] == "e";
    assign m_stclose = f >= 4'd8 && lx[1] == "/" && lx[2] == "s" && lx[3] == "t"
                    && lx[4] == "y" && lx[5] == "l" && lx[6] == "e" && lx[7] == ">";
    assign m_nl = (f >= 4'd2 && lx[1] == "p")
               || (f >= 4'd3 && lx[1] == "b" && lx[2] == "r")
               || (f >= 4'd4 && lx[1] == "d" && lx[2] == "i" && lx[3] == "v")
               || (f >= 4'd3 && lx[1] == "l" && lx[2] == "i")
               || (f >= 4'd3 && lx[1] == "t" && lx[2] == "r")
               || (f >= 4'd3 && lx[1] == "h" && x[2] >= "1" && x[2] <= "6");

    always_comb begin
        n_fill      = r_fill;
        n_skip      = r_skip;
        n_in_tag    = r_in_tag;
        n_script_on = r_script_on;
        n_style_on  = r_style_on;
        n_draining  = r_draining;
        closed      = 1'b0;
        o_tok_push  = 1'b0;
        o_tok.data      = x[0];
        o_tok.is_end    = 1'b0;
        o_tok.from_last = r_draining || i_in_last;
        if (acc) begin
            n_fill = r_fill + 4'd1;
            if (i_in_last) begin
                n_draining = 1'b1;
            end
        end
        if (do_front) begin
            n_fill = r_draining ? r_fill - 4'd1 : r_fill;
            if (r_skip != '0) begin
                n_skip = r_skip - 4'd1;
            end else if (x[0] == "<") begin
                if (m_sopen) begin
                    n_script_on = 1'b1;
                end else if (m_sclose) begin
                    n_script_on = 1'b0;
                    n_skip      = 4'd8;
                    closed      = 1'b1;
                end else if (m_stopen) begin
                    n_style_on = 1'b1;
                end else if (m_stclose) begin
                    n_style_on = 1'b0;
                    n_skip     = 4'd7;
                    closed     = 1'b1;
                end
                if (!closed) begin
                    if (!n_script_on && !n_style_on && m_nl) begin
                        o_tok_push = 1'b1;
                        o_tok.data = hte_pkg::ChLf;
                    end
                    n_in_tag = 1'b1;
                end
            end else if (x[0] == ">") begin
                n_in_tag = 1'b0;
            end else if (!r_in_tag && !r_script_on && !r_style_on) begin
                o_tok_push = 1'b1;
            end
        end
        if (end_push) begin
            o_tok_push   = 1'b1;
            o_tok.data   = '0;
            o_tok.is_end = 1'b1;
            n_fill       = '0;
            n_skip       = '0;
            n_in_tag     = 1'b0;
            n_script_on  = 1'b0;
            n_style_on   = 1'b0;
            n_draining   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_front) begin
            for (int k = 0; k < TD - 1; k++) begin
                r_win[k] <= x[k + 1];
            end
        end else if (acc) begin
            r_win[r_fill] <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_skip      <= '0;
            r_in_tag    <= 1'b0;
            r_script_on <= 1'b0;
            r_style_on  <= 1'b0;
            r_draining  <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_skip      <= n_skip;
            r_in_tag    <= n_in_tag;
            r_script_on <= n_script_on;
            r_style_on  <= n_style_on;
            r_draining  <= n_draining;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 4'(TD - 1))
        else $error("tag window overfilled");
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in_last |=> r_draining)
        else $error("last byte did not start drain");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_push |=> !r_in_tag && !r_script_on && !r_style_on && r_fill == '0)
        else $error("front state not cleared at end of document");

endmodule
`default_nettype wire

// ----- rtl/hte_text_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hte_text_back
// Entity decode, whitespace collapse and trim, result queue.
// ----------------------------------------------------------------------------
module hte_text_back #(
    parameter int OUT_DEPTH = hte_pkg::OutDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  hte_pkg::t_token  i_tok,
    input  wire logic        i_tok_empty,
    output logic             o_tok_pop,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [7:0]       o_out_byte,
    output logic             o_out_valid,
    output logic             o_out_last
);
    localparam int ED = hte_pkg::EntDepth;
    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic [7:0] r_ew [ED];
    logic [2:0] r_efill, n_efill;
    logic [2:0] r_eskip, n_eskip;
    logic       r_blank, n_blank, r_break, n_break, r_seen, n_seen;
    logic [7:0] r_pend [2];
    logic [1:0] r_pcount, n_pcount;
    logic [7:0] r_held;
    logic       r_hv, n_hv;
    logic [4:0] r_lcnt, n_lcnt;
    logic       r_draining, n_draining;

    hte_pkg::t_result r_of [OUT_DEPTH];
    logic [PW-1:0] r_head, r_tail;
    logic [CW-1:0] r_ocount;

    logic [7:0] y [ED];
    logic [2:0] f;
    logic       room, do_tok, tok_front, drain_front, do_front, do_final, rd;
    logic       coll_en, trim_en, is_vis, last_ctx;
    logic [7:0] coll_c, trim_c;
    logic [7:0] em [3];
    logic [1:0] n_em, allow, wn;
    logic [4:0] rem;
    hte_pkg::t_result wl [3];

    assign room        = r_ocount <= CW'(OUT_DEPTH - 3);
    assign do_tok      = !i_tok_empty && !r_draining && room;
    assign o_tok_pop   = do_tok;
    assign tok_front   = do_tok && !i_tok.is_end && r_efill == 3'(ED - 1);
    assign drain_front = r_draining && r_efill != '0 && room;
    assign do_front    = tok_front || drain_front;
    assign do_final    = r_draining && r_efill == '0 && room;
    assign f           = r_draining ? r_efill : 3'(ED);
    assign last_ctx    = r_draining || i_tok.from_last;

    always_comb begin
        for (int k = 0; k < ED; k++) begin
            y[k] = (k == ED - 1 && !r_draining) ? i_tok.data : r_ew[k];
        end
    end

    // entity decode
    always_comb begin
        n_eskip = r_eskip;
        coll_en = 1'b0;
        coll_c  = y[0];
        if (do_front) begin
            if (r_eskip != '0) begin
                n_eskip = r_eskip - 3'd1;
            end else begin
                coll_en = 1'b1;
                if (y[0] == "&") begin
                    if (f >= 3'd5 && y[1] == "a" && y[2] == "m" && y[3] == "p"
                        && y[4] == ";") begin
                        coll_c = "&"; n_eskip = 3'd4;
                    end else if (f >= 3'd4 && y[1] == "l" && y[2] == "t" && y[3] == ";") begin
                        coll_c = "<"; n_eskip = 3'd3;
                    end else if (f >= 3'd4 && y[1] == "g" && y[2] == "t" && y[3] == ";") begin
                        coll_c = ">"; n_eskip = 3'd3;
                    end else if (f >= 3'd6 && y[1] == "q" && y[2] == "u" && y[3] == "o"
                                 && y[4] == "t" && y[5] == ";") begin
                        coll_c = 8'h22; n_eskip = 3'd5;
                    end else if (f >= 3'd6 && y[1] == "n" && y[2] == "b" && y[3] == "s"
                                 && y[4] == "p" && y[5] == ";") begin
                        coll_c = hte_pkg::ChSpace; n_eskip = 3'd5;
                    end else if (f >= 3'd6 && y[1] == "a" && y[2] == "p" && y[3] == "o"
                                 && y[4] == "s" && y[5] == ";") begin
                        coll_c = 8'h27; n_eskip = 3'd5;
                    end
                end
            end
        end
    end

    // whitespace collapse
    always_comb begin
        n_blank = r_blank;
        n_break = r_break;
        trim_en = 1'b0;
        trim_c  = coll_c;
        if (coll_en) begin
            if (coll_c == hte_pkg::ChLf || coll_c == hte_pkg::ChCr) begin
                if (!r_break) begin
                    trim_en = 1'b1;
                    trim_c  = hte_pkg::ChLf;
                    n_break = 1'b1;
                end
                n_blank = 1'b0;
            end else if (coll_c == hte_pkg::ChSpace || coll_c == hte_pkg::ChTab) begin
                if (!r_blank && !r_break) begin
                    trim_en = 1'b1;
                    trim_c  = hte_pkg::ChSpace;
                    n_blank = 1'b1;
                end
            end else begin
                trim_en = 1'b1;
                n_blank = 1'b0;
                n_break = 1'b0;
            end
        end
    end

    // trim and emit
    assign is_vis = trim_en && trim_c != hte_pkg::ChLf && trim_c != hte_pkg::ChSpace;
    assign rem    = 5'(hte_pkg::OutMax) - r_lcnt;

    always_comb begin
        n_seen   = r_seen;
        n_pcount = r_pcount;
        em[0]    = (r_pcount != 2'd0) ? r_pend[0] : trim_c;
        em[1]    = (r_pcount == 2'd2) ? r_pend[1] : trim_c;
        em[2]    = trim_c;
        n_em     = is_vis ? r_pcount + 2'd1 : 2'd0;
        if (trim_en) begin
            if (!is_vis) begin
                if (r_seen && r_pcount != 2'd2) begin
                    n_pcount = r_pcount + 2'd1;
                end
            end else begin
                n_pcount = '0;
                n_seen   = 1'b1;
            end
        end
        allow = (last_ctx && {3'b000, n_em} > rem) ? rem[1:0] : n_em;
    end

    always_comb begin
        n_hv   = r_hv;
        n_lcnt = r_lcnt;
        wn     = '0;
        for (int k = 0; k < 3; k++) begin
            wl[k] = '{data: em[0], valid: 1'b1, last: 1'b0};
        end
        if (allow != '0) begin
            if (r_hv) begin
                wl[0] = '{data: r_held, valid: 1'b1, last: 1'b0};
                wl[1] = '{data: em[0], valid: 1'b1, last: 1'b0};
                wl[2] = '{data: em[1], valid: 1'b1, last: 1'b0};
                wn    = allow;
            end else begin
                wl[0] = '{data: em[0], valid: 1'b1, last: 1'b0};
                wl[1] = '{data: em[1], valid: 1'b1, last: 1'b0};
                wn    = allow - 2'd1;
            end
            n_hv = 1'b1;
            if (last_ctx) begin
                n_lcnt = r_lcnt + 5'(allow);
            end
        end
        if (do_final) begin
            if (r_lcnt != '0) begin
                wl[0] = '{data: r_held, valid: 1'b1, last: 1'b1};
                wn    = 2'd1;
            end else if (r_hv) begin
                wl[0] = '{data: r_held, valid: 1'b1, last: 1'b0};
                wl[1] = '{data: 8'h00, valid: 1'b0, last: 1'b1};
                wn    = 2'd2;
            end else begin
                wl[0] = '{data: 8'h00, valid: 1'b0, last: 1'b1};
                wn    = 2'd1;
            end
            n_hv   = 1'b0;
            n_lcnt = '0;
        end
    end

    always_comb begin
        n_efill    = r_efill;
        n_draining = r_draining;
        if (do_tok && i_tok.is_end) begin
            n_draining = 1'b1;
        end else if (do_tok && !tok_front) begin
            n_efill = r_efill + 3'd1;
        end
        if (drain_front) begin
            n_efill = r_efill - 3'd1;
        end
        if (do_final) begin
            n_draining = 1'b0;
        end
    end

    assign o_empty     = (r_ocount == '0);
    assign rd          = i_pop && !o_empty;
    assign o_out_byte  = r_of[r_head].data;
    assign o_out_valid = r_of[r_head].valid;
    assign o_out_last  = r_of[r_head].last;

    always_ff @(posedge i_clk) begin
        if (do_front) begin
            for (int k = 0; k < ED - 1; k++) begin
                r_ew[k] <= y[k + 1];
            end
        end else if (do_tok && !i_tok.is_end) begin
            r_ew[r_efill] <= i_tok.data;
        end
        if (trim_en && !is_vis && r_seen && r_pcount != 2'd2) begin
            r_pend[r_pcount[0]] <= trim_c;
        end
        if (allow != '0) begin
            r_held <= em[allow - 2'd1];
        end
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < wn) begin
                r_of[r_tail + PW'(k)] <= wl[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_final) begin
            r_eskip  <= '0;
            r_blank  <= 1'b0;
            r_break  <= 1'b0;
            r_seen   <= 1'b0;
            r_pcount <= '0;
        end else begin
            r_eskip  <= n_eskip;
            r_blank  <= n_blank;
            r_break  <= n_break;
            r_seen   <= n_seen;
            r_pcount <= n_pcount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_efill    <= '0;
            r_hv       <= 1'b0;
            r_lcnt     <= '0;
            r_draining <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_ocount   <= '0;
        end else begin
            r_efill    <= n_efill;
            r_hv       <= n_hv;
            r_lcnt     <= n_lcnt;
            r_draining <= n_draining;
            r_tail     <= r_tail + PW'(wn);
            if (rd) begin
                r_head <= r_head + 1'b1;
            end
            r_ocount   <= r_ocount + CW'(wn) - CW'(rd);
        end
    end

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocount <= CW'(OUT_DEPTH))
        else $error("result queue overflow");
    a_cap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lcnt <= 5'(hte_pkg::OutMax))
        else $error("final request count above cap");
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_final |=> !r_hv && r_lcnt == '0 && !r_seen && !r_draining)
        else $error("back state not cleared at end of document");

endmodule
`default_nettype wire

// ----- rtl/html_text_extractor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// html_text_extractor
// HTML byte stream in, plain text bytes out.
// ----------------------------------------------------------------------------
// input side: push a byte with i_in_byte/i_in_last while full is low.
// result side: while empty is low the oldest result sits on o_out_*;
// pop takes it. o_out_valid 0 marks an empty-text terminator.
// one byte is taken per cycle while full is low; when not stalled the tag
// front handles one window position a cycle, the back one entity position.
// text is delayed by the 9-byte tag and 6-byte entity lookahead windows
// and registered in the request queue and result queue; the newest
// character is held back until the next one or the end of the document.
// after a last byte the input is held off while the tag window drains;
// the back then drains the entity window and closes the document with
// out_last on its final result.
// a single visible character may release up to 3 results at once; the back
// stalls until the result queue has room, and a stalled receiver backs up
// through the queues to full.
// reset (synchronous) empties both queues and clears all window state.
// OUT_DEPTH must be a power of two of at least 4.
// ----------------------------------------------------------------------------
module html_text_extractor #(
    parameter int QUEUE_DEPTH = hte_pkg::QueueDepth,
    parameter int OUT_DEPTH   = hte_pkg::OutDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_out_valid,
    output logic            o_out_last
);
    hte_pkg::t_token tok_in, tok_out;
    logic            tok_push, tok_full, tok_pop, tok_empty;

    hte_tag_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_full     (full),
        .o_tok_push (tok_push),
        .o_tok      (tok_in),
        .i_tok_full (tok_full)
    );

    hte_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .o_full  (tok_full),
        .i_pop   (tok_pop),
        .o_data  (tok_out),
        .o_empty (tok_empty)
    );

    hte_text_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (tok_out),
        .i_tok_empty (tok_empty),
        .o_tok_pop   (tok_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_out_valid (o_out_valid),
        .o_out_last  (o_out_last)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks html_text_extractor against a cycle-free text prediction: documents
// of tags, entities, whitespace and noise go in through the request queue,
// every popped result is compared with the oldest predicted text byte.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } t_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       pop = 1'b0;
    wire        full;
    wire        empty;
    wire  [7:0] o_out_byte;
    wire        o_out_valid;
    wire        o_out_last;

    hte_pkg::t_result text_q[$];
    t_req             req_q[$];
    logic [7:0]       doc_q[$];
    logic [7:0]       step_chars[$];
    int               errors = 0;
    int               accepted = 0;
    int               total = 0;
    longint           cycles = 0;

    logic [7:0] tw[9];
    int         tw_fill, close_skip;
    bit         in_tag, in_scr, in_sty;
    logic [7:0] ew[6];
    int         ew_fill, ent_skip;
    bit         was_blank, was_break, seen_vis;
    logic [7:0] spaces[2];
    int         space_cnt;

    html_text_extractor DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_in_byte(i_in_byte), .i_in_last(i_in_last), .empty(empty), .pop(pop),
        .o_out_byte(o_out_byte), .o_out_valid(o_out_valid), .o_out_last(o_out_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic [7:0] fold(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic void clear_text_state();
        tw_fill = 0; close_skip = 0; in_tag = 0; in_scr = 0; in_sty = 0;
        ew_fill = 0; ent_skip = 0; was_blank = 0; was_break = 0; seen_vis = 0;
        space_cnt = 0;
        foreach (tw[k]) tw[k] = 8'h00;
        foreach (ew[k]) ew[k] = 8'h00;
    endfunction

    function automatic void trim_char(logic [7:0] c);
        if (is_space(c)) begin
            if (seen_vis && space_cnt < 2) begin
                spaces[space_cnt] = c;
                space_cnt++;
            end
            return;
        end
        for (int k = 0; k < space_cnt; k++) step_chars.push_back(spaces[k]);
        space_cnt = 0;
        seen_vis = 1;
        step_chars.push_back(c);
    endfunction

    function automatic void collapse_char(logic [7:0] c);
        if (c == 8'h0A || c == 8'h0D) begin
            if (!was_break) begin
                trim_char(8'h0A);
                was_break = 1;
            end
            was_blank = 0;
        end else if (c == 8'h20 || c == 8'h09) begin
            if (!was_blank && !was_break) begin
                trim_char(8'h20);
                was_blank = 1;
            end
        end else begin
            trim_char(c);
            was_blank = 0;
            was_break = 0;
        end
    endfunction

    function automatic bit ent_is(string pat);
        if (pat.len() > ew_fill) return 0;
        for (int k = 0; k < pat.len(); k++)
            if (ew[k] != pat[k]) return 0;
        return 1;
    endfunction

    function automatic void ent_front();
        logic [7:0] c;
        c = ew[0];
        if (ent_skip > 0) ent_skip--;
        else if (c == "&") begin
            if (ent_is("&amp;")) begin collapse_char("&"); ent_skip = 4; end
            else if (ent_is("&lt;")) begin collapse_char("<"); ent_skip = 3; end
            else if (ent_is("&gt;")) begin collapse_char(">"); ent_skip = 3; end
            else if (ent_is("&quot;")) begin collapse_char(8'h22); ent_skip = 5; end
            else if (ent_is("&nbsp;")) begin collapse_char(" "); ent_skip = 5; end
            else if (ent_is("&apos;")) begin collapse_char(8'h27); ent_skip = 5; end
            else collapse_char(c);
        end else collapse_char(c);
        for (int k = 0; k < 5; k++) ew[k] = ew[k+1];
        if (ew_fill > 0) ew_fill--;
    endfunction

    function automatic void ent_push(logic [7:0] c);
        if (ew_fill < 6) begin
            ew[ew_fill] = c;
            ew_fill++;
        end
        if (ew_fill >= 6) ent_front();
    endfunction

    function automatic bit tag_is(string pat);
        if (pat.len() > tw_fill) return 0;
        for (int k = 0; k < pat.len(); k++)
            if (fold(tw[k]) != pat[k]) return 0;
        return 1;
    endfunction

    function automatic void tag_front();
        logic [7:0] c;
        bit         closed;
        c = tw[0];
        closed = 0;
        if (close_skip > 0) close_skip--;
        else if (c == "<") begin
            if (tag_is("<script")) in_scr = 1;
            else if (tag_is("</script>")) begin
                in_scr = 0; close_skip = 8; closed = 1;
            end else if (tag_is("<style")) in_sty = 1;
            else if (tag_is("</style>")) begin
                in_sty = 0; close_skip = 7; closed = 1;
            end
            if (!closed) begin
                if (!in_scr && !in_sty &&
                    (tag_is("<p") || tag_is("<br") || tag_is("<div") ||
                     tag_is("<li") || tag_is("<tr") ||
                     (tw_fill >= 3 && fold(tw[1]) == "h" &&
                      tw[2] >= "1" && tw[2] <= "6")))
                    ent_push(8'h0A);
                in_tag = 1;
            end
        end else if (c == ">") in_tag = 0;
        else if (!in_tag && !in_scr && !in_sty) ent_push(c);
        for (int k = 0; k < 8; k++) tw[k] = tw[k+1];
        if (tw_fill > 0) tw_fill--;
    endfunction

    function automatic void predict_text(logic [7:0] b, logic is_last);
        hte_pkg::t_result r;
        step_chars.delete();
        if (tw_fill < 9) begin
            tw[tw_fill] = b;
            tw_fill++;
        end
        if (tw_fill >= 9) tag_front();
        if (is_last) begin
            while (tw_fill > 0) tag_front();
            while (ew_fill > 0) ent_front();
        end
        foreach (step_chars[k]) begin
            if (k < 16) begin
                r.data = step_chars[k];
                r.valid = 1'b1;
                r.last = is_last && (k + 1 == step_chars.size() || k == 15);
                text_q.push_back(r);
            end
        end
        if (is_last) begin
            if (step_chars.size() == 0) begin
                r.data = 8'h00; r.valid = 1'b0; r.last = 1'b1;
                text_q.push_back(r);
            end
            clear_text_state();
        end
    endfunction

    function automatic void put_str(string s);
        for (int k = 0; k < s.len(); k++) doc_q.push_back(s[k]);
    endfunction

    function automatic void put_byte(logic [7:0] c);
        doc_q.push_back(c);
    endfunction

    function automatic void add_doc(bit hold_first);
        t_req r;
        foreach (doc_q[k]) begin
            r.data = doc_q[k];
            r.last = (k == doc_q.size() - 1);
            r.hold = hold_first && k == 0;
            req_q.push_back(r);
            total++;
        end
        doc_q.delete();
    endfunction

    function automatic bit quiet();
        return accepted >= 150 && accepted < 260;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_text(i_in_byte, i_in_last);
                accepted++;
            end
            if (!push || !full) begin
                if (req_q.size() > 0 && (quiet() || $urandom_range(99) >= 16) &&
                    !(req_q[0].hold && text_q.size() > 0)) begin
                    r = req_q.pop_front();
                    push <= 1'b1;
                    i_in_byte <= r.data;
                    i_in_last <= r.last;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        hte_pkg::t_result e;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (text_q.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h/%b/%b",
                             $time, o_out_byte, o_out_valid, o_out_last);
                    errors++;
                end else begin
                    e = text_q.pop_front();
                    if (o_out_byte !== e.data) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, e.data, o_out_byte);
                        errors++;
                    end
                    if (o_out_valid !== e.valid) begin
                        $display("%0t: out_valid expected %b actual %b",
                                 $time, e.valid, o_out_valid);
                        errors++;
                    end
                    if (o_out_last !== e.last) begin
                        $display("%0t: out_last expected %b actual %b",
                                 $time, e.last, o_out_last);
                        errors++;
                    end
                end
            end
            pop <= quiet() || $urandom_range(99) >= 16;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        string pieces[$];
        int    n;
        clear_text_state();
        pieces = '{"<p>", "<BR>", "<div class=x>", "<li>", "<tr>", "<h3>", "<H7>",
                   "<Script>", "</script>", "<style>", "</STYLE>", "</sCRIPT>", "<b>",
                   "&amp;", "&lt;", "&gt;", "&quot;", "&nbsp;", "&apos;", "&AMP;",
                   "&am", " ", "\t", "\015", "\n", "  ", "abc", "X", ">", "<"};
        // directed: headings, entity, mixed blanks, high byte, empty text, short entity
        put_str("  <H2>A&amp;\t \015\n");
        put_byte(8'hFF);
        put_byte(8'h00);
        put_str(" ");
        add_doc(0);
        put_str(" ");
        add_doc(0);
        put_str("x&lt");
        add_doc(1);
        while (total < 445) begin
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++) put_byte(8'($urandom_range(255)));
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(4) == 0)
                        put_byte(8'($urandom_range(255)));
                    else
                        put_str(pieces[$urandom_range(pieces.size() - 1)]);
                end
            end
            add_doc($urandom_range(9) == 0);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (accepted == total);
        wait (text_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
